>>> rtl/vibe_pattern_and_backlight_timer_core_macros.svh
// ----------------------------------------------------------------------------
// Vibe pattern and backlight timer: assertion macros
// Shared concurrent assertion wrappers; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef VIBE_PATTERN_AND_BACKLIGHT_TIMER_CORE_MACROS_SVH
`define VIBE_PATTERN_AND_BACKLIGHT_TIMER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property holds at every edge out of reset
`define VPBT_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error("assertion failed: %m");
// Consequent holds in the cycle after the antecedent
`define VPBT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define VPBT_ASSERT(lbl, clk_s, rst_s, prop)
`define VPBT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> rtl/vpbt_pkg.sv
// ----------------------------------------------------------------------------
// Vibe pattern and backlight timer package
// Operation codes, light modes, queue sizing and shared types.
// ----------------------------------------------------------------------------
package vpbt_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W       = 16;
  localparam int CNT_OUT_W   = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic [CFG_DATA_W-1:0] SHORT_RST   = 16'd100;
  localparam logic [CFG_DATA_W-1:0] LONG_RST    = 16'd500;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 16'd3000;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  typedef logic [QIDX_W-1:0] qidx_t;
  typedef logic [QCNT_W-1:0] qcnt_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_PUSH     = 3'd1,
    OP_SHORT    = 3'd2,
    OP_LONG     = 3'd3,
    OP_DOUBLE   = 3'd4,
    OP_CANCEL   = 3'd5,
    OP_LIGHT    = 3'd6,
    OP_INTERACT = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    LIGHT_OFF   = 2'd0,
    LIGHT_ON    = 2'd1,
    LIGHT_TIMED = 2'd2
  } light_mode_t;

  typedef struct packed {
    op_t  op;
    len_t segment_ms;
    logic segment_on;
    logic light_always_on;
  } item_t;

  typedef struct packed {
    logic                 motor_on;
    logic [CNT_OUT_W-1:0] queued_segments;
    logic                 push_dropped;
  } q_stat_t;

  // ring index wrap; sum stays below twice the depth
  function automatic qidx_t wrap_idx(input logic [QCNT_W:0] sum);
    logic [QCNT_W:0] adj;
    adj = sum;
    if (sum >= (QCNT_W+1)'(QUEUE_DEPTH)) begin
      adj = sum - (QCNT_W+1)'(QUEUE_DEPTH);
    end
    return QIDX_W'(adj);
  endfunction

endpackage

>>> rtl/vpbt_queue.sv
// ----------------------------------------------------------------------------
// Segment queue and motor playback
// Ring of timed segments, preset pushes, cancel and per-tick playback.
// ----------------------------------------------------------------------------
`include "vibe_pattern_and_backlight_timer_core_macros.svh"

module vpbt_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  vpbt_pkg::item_t                  item,
  input  logic [vpbt_pkg::CFG_DATA_W-1:0]  short_ms,
  input  logic [vpbt_pkg::CFG_DATA_W-1:0]  long_ms,
  output vpbt_pkg::q_stat_t                stat
);
  import vpbt_pkg::*;

  logic  flag_r [QUEUE_DEPTH];
  len_t  len_r  [QUEUE_DEPTH];

  qidx_t head_r, head_nxt;
  qcnt_t count_r, count_nxt;
  logic  started_r, started_nxt;
  logic  motor_r, motor_nxt;
  len_t  elapsed_r, elapsed_nxt;

  logic            cur_flag;
  len_t            cur_len;
  logic [QCNT_W:0] need;
  logic [QCNT_W:0] base;
  logic            room;
  logic            dropped;
  logic [2:0]      wr_en;
  logic [2:0]      wr_flag;
  len_t            wr_len;
  qidx_t           wr_addr [3];
  len_t            el;

  assign cur_flag = flag_r[head_r];
  assign cur_len  = len_r[head_r];
  assign base     = (QCNT_W+1)'(head_r) + (QCNT_W+1)'(count_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wr_addr[k] = wrap_idx(base + (QCNT_W+1)'(k));
    end
  end

  always_comb begin
    need = (item.op == OP_DOUBLE) ? (QCNT_W+1)'(3) : (QCNT_W+1)'(1);
    room = ((QCNT_W+1)'(count_r) + need) <= (QCNT_W+1)'(QUEUE_DEPTH);
  end

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    started_nxt = started_r;
    motor_nxt   = motor_r;
    elapsed_nxt = elapsed_r;
    dropped     = 1'b0;
    wr_en       = 3'b000;
    wr_flag     = 3'b101;
    wr_len      = short_ms;
    el          = elapsed_r;
    case (item.op)
      OP_TICK: begin
        if (count_r != '0) begin
          if (!started_r) begin
            started_nxt = 1'b1;
            el          = '0;
            motor_nxt   = cur_flag;
          end else if (elapsed_r != LEN_MAX) begin
            el = elapsed_r + 1'b1;
          end
          elapsed_nxt = el;
          if (el >= cur_len) begin
            head_nxt    = (head_r == QIDX_W'(QUEUE_DEPTH-1)) ? '0 : head_r + 1'b1;
            count_nxt   = count_r - 1'b1;
            started_nxt = 1'b0;
            elapsed_nxt = '0;
            if (count_r == qcnt_t'(1)) begin
              motor_nxt = 1'b0;
            end
          end
        end
      end
      OP_PUSH, OP_SHORT, OP_LONG, OP_DOUBLE: begin
        if (item.op == OP_PUSH) begin
          wr_len     = item.segment_ms;
          wr_flag[0] = item.segment_on;
        end else if (item.op == OP_LONG) begin
          wr_len = long_ms;
        end
        if (room) begin
          wr_en     = (item.op == OP_DOUBLE) ? 3'b111 : 3'b001;
          count_nxt = QCNT_W'((QCNT_W+1)'(count_r) + need);
        end else begin
          dropped = 1'b1;
        end
      end
      OP_CANCEL: begin
        head_nxt    = '0;
        count_nxt   = '0;
        started_nxt = 1'b0;
        elapsed_nxt = '0;
        motor_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign stat.motor_on        = motor_nxt;
  assign stat.queued_segments = CNT_OUT_W'(count_nxt);
  assign stat.push_dropped    = dropped;

  // segment store, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (step && wr_en[k]) begin
        flag_r[wr_addr[k]] <= wr_flag[k];
        len_r[wr_addr[k]]  <= wr_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      started_r <= 1'b0;
      motor_r   <= 1'b0;
      elapsed_r <= '0;
    end else if (step) begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      started_r <= started_nxt;
      motor_r   <= motor_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  `VPBT_ASSERT(a_count_bound, clk, rst_n, count_r <= QCNT_W'(QUEUE_DEPTH))
  `VPBT_ASSERT(a_started_busy, clk, rst_n, !started_r || (count_r != '0))
  `VPBT_ASSERT_NEXT(a_cancel_clear, clk, rst_n, step && item.op == OP_CANCEL, count_r == '0 && !motor_r && !started_r)

endmodule

>>> rtl/vpbt_light.sv
// ----------------------------------------------------------------------------
// Backlight timer
// Off, always-on or timed backlight with saturating tick counter.
// ----------------------------------------------------------------------------
`include "vibe_pattern_and_backlight_timer_core_macros.svh"

module vpbt_light (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  vpbt_pkg::item_t                 item,
  input  logic [vpbt_pkg::CFG_DATA_W-1:0] timeout_ms,
  output logic                            backlight_on
);
  import vpbt_pkg::*;

  light_mode_t mode_r, mode_nxt;
  len_t        elapsed_r, elapsed_nxt;
  len_t        el;

  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    el          = elapsed_r;
    case (item.op)
      OP_TICK: begin
        if (mode_r == LIGHT_TIMED) begin
          if (elapsed_r != LEN_MAX) begin
            el = elapsed_r + 1'b1;
          end
          elapsed_nxt = el;
          if (el >= timeout_ms) begin
            mode_nxt = LIGHT_OFF;
          end
        end
      end
      OP_LIGHT: begin
        mode_nxt = item.light_always_on ? LIGHT_ON : LIGHT_OFF;
      end
      OP_INTERACT: begin
        elapsed_nxt = '0;
        mode_nxt    = (timeout_ms != '0) ? LIGHT_TIMED : LIGHT_OFF;
      end
      default: begin
      end
    endcase
  end

  assign backlight_on = (mode_nxt != LIGHT_OFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= LIGHT_OFF;
      elapsed_r <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  `VPBT_ASSERT_NEXT(a_interact_timed, clk, rst_n, step && item.op == OP_INTERACT && timeout_ms != '0, mode_r == LIGHT_TIMED && elapsed_r == '0)
  `VPBT_ASSERT_NEXT(a_light_set, clk, rst_n, step && item.op == OP_LIGHT, mode_r == ($past(item.light_always_on) ? LIGHT_ON : LIGHT_OFF))

endmodule

>>> rtl/vibe_pattern_and_backlight_timer_core.sv
// ----------------------------------------------------------------------------
// Vibe pattern and backlight timer core
// Motor segment sequencer and backlight timer behind stream interfaces.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: operation; tdata: segment fields
//  out_    | out | out_tvalid/tready  | tdata: motor, backlight, count, dropped
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
//  One item per clock while the output is not stalled: an item waits in the
//  input register, the queue and light updates run in the cycle it advances
//  and the result lands in the output register, which drives out_tvalid.
//  Reset is synchronous; no clearing pass, the segment store is uninitialised.
//  A stalled output holds its result while one more item waits in the input
//  register.
// ----------------------------------------------------------------------------
`include "vibe_pattern_and_backlight_timer_core_macros.svh"

module vibe_pattern_and_backlight_timer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,  // segment_ms, segment_on, light_always_on
  input  logic [2:0]                        in_tuser,  // operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata, // motor_on, backlight_on, queued_segments, push_dropped
  input  logic                              cfg_we,
  input  logic [vpbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpbt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vpbt_pkg::*;

  logic [CFG_DATA_W-1:0] short_r, long_r, timeout_r;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r;
  logic [7:0] out_data_r;
  logic    advance;
  logic    in_acc;
  q_stat_t q_stat;
  logic    light_on;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r   <= SHORT_RST;
      long_r    <= LONG_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT:   short_r   <= cfg_wdata;
        CFG_LONG:    long_r    <= cfg_wdata;
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op              <= op_t'(in_tuser);
      s1_item_r.segment_ms      <= in_tdata[15:0];
      s1_item_r.segment_on      <= in_tdata[16];
      s1_item_r.light_always_on <= in_tdata[17];
    end
  end

  vpbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (s1_item_r),
    .short_ms (short_r),
    .long_ms  (long_r),
    .stat     (q_stat)
  );

  vpbt_light u_light (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .item         (s1_item_r),
    .timeout_ms   (timeout_r),
    .backlight_on (light_on)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {q_stat.push_dropped, q_stat.queued_segments, light_on, q_stat.motor_on};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `VPBT_ASSERT_NEXT(a_stage_hold, clk, rst_n, s1_valid_r && !advance, s1_valid_r && $stable(s1_item_r))
  `VPBT_ASSERT_NEXT(a_result_follows, clk, rst_n, advance, out_valid_r)
  `VPBT_ASSERT(a_no_overrun, clk, rst_n, !(advance && out_valid_r && !out_tready))

endmodule

>>> test/vpbt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibe pattern and backlight timer: result checker
// Watches the input, result and register ports, keeps its own segment queue,
// motor and backlight state, and compares each result item, field by field,
// against the oldest predicted status.
// ----------------------------------------------------------------------------
module vpbt_checker
  import vpbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [23:0]           in_tdata,  // segment_ms, segment_on, light_always_on
  input  logic [2:0]            in_tuser,  // operation
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata, // motor_on, backlight_on, queued_segments, push_dropped
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    awaiting,
  output int                    results_checked,
  output int                    drops_seen
);

  typedef struct {
    logic       motor;
    logic       light;
    logic [4:0] count;
    logic       dropped;
  } status_t;

  len_t        short_len;
  len_t        long_len;
  len_t        light_timeout;

  logic        seg_on_flag [QUEUE_DEPTH];
  len_t        seg_len [QUEUE_DEPTH];
  qidx_t       head;
  int unsigned depth_used;
  logic        playing;
  logic        motor;
  len_t        seg_ticks;
  light_mode_t light;
  len_t        light_ticks;

  status_t     pending_status [$];

  initial begin
    fail_count      = 0;
    awaiting        = 0;
    results_checked = 0;
    drops_seen      = 0;
  end

  function automatic void queue_segment(len_t len, logic on);
    qidx_t slot;
    slot = qidx_t'((int'(head) + depth_used) % QUEUE_DEPTH);
    seg_on_flag[slot] = on;
    seg_len[slot]     = len;
    depth_used++;
  endfunction

  function automatic status_t predict_status(op_t op, len_t ms, logic on, logic always_on);
    status_t s;
    s.dropped = 1'b0;
    case (op)
      OP_TICK: begin
        if (depth_used > 0) begin
          if (!playing) begin
            playing   = 1'b1;
            seg_ticks = '0;
            motor     = seg_on_flag[head];
          end else if (seg_ticks != LEN_MAX) begin
            seg_ticks++;
          end
          if (seg_ticks >= seg_len[head]) begin
            head      = head + 1'b1;
            depth_used--;
            playing   = 1'b0;
            seg_ticks = '0;
            if (depth_used == 0) motor = 1'b0;
          end
        end
        if (light == LIGHT_TIMED) begin
          if (light_ticks != LEN_MAX) light_ticks++;
          if (light_ticks >= light_timeout) light = LIGHT_OFF;
        end
      end
      OP_PUSH: begin
        if (depth_used + 1 <= QUEUE_DEPTH) queue_segment(ms, on);
        else s.dropped = 1'b1;
      end
      OP_SHORT: begin
        if (depth_used + 1 <= QUEUE_DEPTH) queue_segment(short_len, 1'b1);
        else s.dropped = 1'b1;
      end
      OP_LONG: begin
        if (depth_used + 1 <= QUEUE_DEPTH) queue_segment(long_len, 1'b1);
        else s.dropped = 1'b1;
      end
      OP_DOUBLE: begin
        if (depth_used + 3 <= QUEUE_DEPTH) begin
          queue_segment(short_len, 1'b1);
          queue_segment(short_len, 1'b0);
          queue_segment(short_len, 1'b1);
        end else begin
          s.dropped = 1'b1;
        end
      end
      OP_CANCEL: begin
        head       = '0;
        depth_used = 0;
        playing    = 1'b0;
        seg_ticks  = '0;
        motor      = 1'b0;
      end
      OP_LIGHT: begin
        light = always_on ? LIGHT_ON : LIGHT_OFF;
      end
      OP_INTERACT: begin
        light_ticks = '0;
        light       = (light_timeout != '0) ? LIGHT_TIMED : LIGHT_OFF;
      end
    endcase
    s.motor = motor;
    s.light = (light != LIGHT_OFF);
    s.count = 5'(depth_used);
    return s;
  endfunction

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      short_len     = SHORT_RST;
      long_len      = LONG_RST;
      light_timeout = TIMEOUT_RST;
      head          = '0;
      depth_used    = 0;
      playing       = 1'b0;
      motor         = 1'b0;
      seg_ticks     = '0;
      light         = LIGHT_OFF;
      light_ticks   = '0;
      pending_status.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %b", $time, out_tdata);
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          results_checked++;
          compare_field("motor_on", want.motor, out_tdata[0]);
          compare_field("backlight_on", want.light, out_tdata[1]);
          compare_field("queued_segments", want.count, out_tdata[6:2]);
          compare_field("push_dropped", want.dropped, out_tdata[7]);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHORT:   short_len     = cfg_wdata;
          CFG_LONG:    long_len      = cfg_wdata;
          CFG_TIMEOUT: light_timeout = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = predict_status(op_t'(in_tuser), in_tdata[15:0], in_tdata[16], in_tdata[17]);
        if (want.dropped) drops_seen++;
        pending_status.push_back(want);
      end
    end
    awaiting = pending_status.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibe pattern and backlight timer: testbench top
// Drives directed operations under the reset values and random operations into
// the core under four register settings, with random gaps on both stream sides
// in the first two, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import vpbt_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int ITEMS_PER_STEP = 470;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [23:0]           in_tdata   = '0;
  logic [2:0]            in_tuser   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire  [7:0]            out_tdata;

  int fail_count;
  int awaiting;
  int results_checked;
  int drops_seen;
  int send_idle_pct = 14;
  int take_idle_pct = 69;
  int items_sent    = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  always #6 clk = ~clk;

  vibe_pattern_and_backlight_timer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  vpbt_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .drops_seen      (drops_seen)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(op_t op, len_t ms, logic on, logic always_on);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, always_on, on, ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained(int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // registers are only written with the core idle
  task automatic apply_setting(len_t short_ms, len_t long_ms, len_t timeout_ms);
    wait_drained(4);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SHORT;
    cfg_wdata <= short_ms;
    @(negedge clk);
    cfg_index <= CFG_LONG;
    cfg_wdata <= long_ms;
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= timeout_ms;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  task automatic send_directed_items();
    send_item(OP_TICK, '0, 1'b0, 1'b0);            // tick on an empty queue
    send_item(OP_INTERACT, '0, 1'b0, 1'b0);
    send_item(OP_LIGHT, LEN_MAX, 1'b1, 1'b1);       // overrides the timeout
    send_item(OP_LIGHT, '0, 1'b0, 1'b0);
    send_item(OP_PUSH, '0, 1'b1, 1'b0);             // zero length: starts and ends at once
    send_item(OP_TICK, '0, 1'b0, 1'b0);
    send_item(OP_PUSH, LEN_MAX, 1'b1, 1'b1);
    send_item(OP_PUSH, '0, 1'b0, 1'b0);
    send_item(OP_SHORT, '0, 1'b0, 1'b0);
    send_item(OP_LONG, '0, 1'b0, 1'b0);
    send_item(OP_DOUBLE, '0, 1'b0, 1'b0);
    repeat (7) send_item(OP_PUSH, 16'h5A5A, 1'b1, 1'b0);
    send_item(OP_DOUBLE, '0, 1'b0, 1'b0);           // two slots left: dropped
    send_item(OP_PUSH, 16'hA5A5, 1'b0, 1'b1);
    send_item(OP_PUSH, 16'h0001, 1'b1, 1'b0);       // queue now full
    send_item(OP_PUSH, 16'h0002, 1'b1, 1'b0);
    send_item(OP_SHORT, '0, 1'b0, 1'b0);
    send_item(OP_LONG, '0, 1'b0, 1'b0);
    send_item(OP_TICK, '0, 1'b0, 1'b0);
    send_item(OP_CANCEL, '0, 1'b0, 1'b0);
    send_item(OP_TICK, '0, 1'b0, 1'b0);
  endtask

  task automatic send_random_items(int count);
    int   pick;
    op_t  op;
    len_t ms;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 48)      op = OP_TICK;
      else if (pick < 64) op = OP_PUSH;
      else if (pick < 70) op = OP_SHORT;
      else if (pick < 74) op = OP_LONG;
      else if (pick < 79) op = OP_DOUBLE;
      else if (pick < 82) op = OP_CANCEL;
      else if (pick < 89) op = OP_LIGHT;
      else                op = OP_INTERACT;
      pick = $urandom_range(99);
      if (pick < 80)      ms = len_t'($urandom_range(6));
      else if (pick < 95) ms = len_t'($urandom_range(40));
      else                ms = len_t'($urandom);
      send_item(op, ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if ($urandom_range(149) == 0) wait_drained(0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_directed_items();
    apply_setting(16'd3, 16'd6, 16'd5);
    send_random_items(ITEMS_PER_STEP);

    apply_setting(16'd0, 16'hFFFF, 16'd0);
    send_idle_pct = 69;
    take_idle_pct = 14;
    send_random_items(ITEMS_PER_STEP);

    apply_setting(16'd1, 16'd2, 16'hFFFF);
    send_idle_pct = 0;
    take_idle_pct = 0;
    send_random_items(ITEMS_PER_STEP);

    apply_setting(16'hFFFF, 16'd0, 16'd1);
    send_random_items(ITEMS_PER_STEP);

    wait_drained(8);
    $display("Ran %0d operation items under %0d register settings plus reset values.",
             items_sent, settings_used);
    $display("Checked %0d status items, %0d of them dropped pushes.",
             results_checked, drops_seen);
    if (fail_count == 0 && awaiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
